/* rtl/artd_pkg.sv */
// Shared types and constants for the run-coded sprite decoder.
// No dependencies; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package artd_pkg;

	localparam int unsigned MAX_WIDTH    = 1024;
	localparam int unsigned MAX_ROW_SPAN = 2048;
	localparam int unsigned HEIGHT_LIMIT = 5120 / 2;
	localparam int unsigned RUN_W        = $clog2(MAX_ROW_SPAN);

	localparam logic [15:0] VALUE_FLAG = 16'h8000;

	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned IN_TUSER_W  = 1;
	localparam int unsigned OUT_FIELD_W = 16 + 12 + 16;
	localparam int unsigned OUT_TDATA_W = 48;
	localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
	localparam int unsigned OUT_TUSER_W = 3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FLAG2,
		PH_WIDTH,
		PH_HEIGHT,
		PH_OFFSETS,
		PH_SKIP,
		PH_RUN,
		PH_PIXELS
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PIXEL      = 3'd0,
		KIND_DONE       = 3'd1,
		KIND_BAD_WIDTH  = 3'd2,
		KIND_BAD_HEIGHT = 3'd3,
		KIND_BAD_RUN    = 3'd4
	} kind_t;

	typedef struct packed {
		logic [15:0] data_word;
		logic        tile_start;
	} item_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [15:0] pixel_x;
		logic [11:0] pixel_y;
		logic [15:0] pixel_value;
	} result_t;

endpackage

`default_nettype wire

/* rtl/artd_in.sv */
// Input register stage for the sprite decoder request stream.
// Depends on artd_pkg for the item type and stream widths.
`timescale 1ns / 1ps
`default_nettype none

module artd_in (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  [artd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  wire  [artd_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	input  wire                                  adv,
	output logic                                 valid_s1,
	output artd_pkg::item_t                      item_s1
);

	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data_word  <= s_axis_tdata;
			item_s1.tile_start <= s_axis_tuser[0];
		end
	end

endmodule

`default_nettype wire

/* rtl/artd_parse.sv */
// Sprite parser: phase register, row counters and the result for one word.
// Depends on artd_pkg for phase, kind, item and result types.
`timescale 1ns / 1ps
`default_nettype none

module artd_parse (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                fire,
	input  artd_pkg::item_t    item_s1,
	output artd_pkg::result_t  res
);

	artd_pkg::phase_t             phase_q, phase_d;
	logic [11:0]                  sprite_height_q, sprite_height_d;
	logic [11:0]                  offsets_left_q, offsets_left_d;
	logic [15:0]                  cursor_x_q, cursor_x_d;
	logic [11:0]                  cursor_y_q, cursor_y_d;
	logic [15:0]                  pending_skip_q, pending_skip_d;
	logic [artd_pkg::RUN_W-1:0]   run_left_q, run_left_d;

	logic [15:0] w;
	logic [16:0] span;
	logic [11:0] y_inc;
	logic [11:0] off_dec;

	assign w       = item_s1.data_word;
	assign span    = {1'b0, pending_skip_q} + {1'b0, w};
	assign y_inc   = cursor_y_q + 12'd1;
	assign off_dec = offsets_left_q - 12'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= artd_pkg::PH_IDLE;
			sprite_height_q <= '0;
			offsets_left_q  <= '0;
			cursor_x_q      <= '0;
			cursor_y_q      <= '0;
			pending_skip_q  <= '0;
			run_left_q      <= '0;
		end else if (fire) begin
			phase_q         <= phase_d;
			sprite_height_q <= sprite_height_d;
			offsets_left_q  <= offsets_left_d;
			cursor_x_q      <= cursor_x_d;
			cursor_y_q      <= cursor_y_d;
			pending_skip_q  <= pending_skip_d;
			run_left_q      <= run_left_d;
		end
	end

	always_comb begin
		phase_d         = phase_q;
		sprite_height_d = sprite_height_q;
		offsets_left_d  = offsets_left_q;
		cursor_x_d      = cursor_x_q;
		cursor_y_d      = cursor_y_q;
		pending_skip_d  = pending_skip_q;
		run_left_d      = run_left_q;
		res             = '0;
		res.kind        = artd_pkg::KIND_PIXEL;

		if (item_s1.tile_start) begin
			phase_d = artd_pkg::PH_FLAG2;
		end else begin
			case (phase_q)
				artd_pkg::PH_IDLE: begin
					phase_d = artd_pkg::PH_IDLE;
				end
				artd_pkg::PH_FLAG2: begin
					phase_d = artd_pkg::PH_WIDTH;
				end
				artd_pkg::PH_WIDTH: begin
					if (w == 16'd0 || w >= 16'(artd_pkg::MAX_WIDTH)) begin
						phase_d   = artd_pkg::PH_IDLE;
						res.valid = 1'b1;
						res.kind  = artd_pkg::KIND_BAD_WIDTH;
					end else begin
						phase_d = artd_pkg::PH_HEIGHT;
					end
				end
				artd_pkg::PH_HEIGHT: begin
					if (w == 16'd0 || w > 16'(artd_pkg::HEIGHT_LIMIT)) begin
						phase_d   = artd_pkg::PH_IDLE;
						res.valid = 1'b1;
						res.kind  = artd_pkg::KIND_BAD_HEIGHT;
					end else begin
						sprite_height_d = w[11:0];
						offsets_left_d  = w[11:0];
						phase_d         = artd_pkg::PH_OFFSETS;
					end
				end
				artd_pkg::PH_OFFSETS: begin
					offsets_left_d = off_dec;
					if (off_dec == 12'd0) begin
						cursor_x_d = '0;
						cursor_y_d = '0;
						phase_d    = artd_pkg::PH_SKIP;
					end
				end
				artd_pkg::PH_SKIP: begin
					pending_skip_d = w;
					phase_d        = artd_pkg::PH_RUN;
				end
				artd_pkg::PH_RUN: begin
					if (span == 17'd0) begin
						cursor_x_d = '0;
						cursor_y_d = y_inc;
						if (y_inc >= sprite_height_q) begin
							phase_d   = artd_pkg::PH_IDLE;
							res.valid = 1'b1;
							res.kind  = artd_pkg::KIND_DONE;
						end else begin
							phase_d = artd_pkg::PH_SKIP;
						end
					end else if (span >= 17'(artd_pkg::MAX_ROW_SPAN)) begin
						phase_d   = artd_pkg::PH_IDLE;
						res.valid = 1'b1;
						res.kind  = artd_pkg::KIND_BAD_RUN;
					end else begin
						cursor_x_d = cursor_x_q + pending_skip_q;
						if (w == 16'd0) begin
							phase_d = artd_pkg::PH_SKIP;
						end else begin
							run_left_d = w[artd_pkg::RUN_W-1:0];
							phase_d    = artd_pkg::PH_PIXELS;
						end
					end
				end
				artd_pkg::PH_PIXELS: begin
					res.valid       = 1'b1;
					res.kind        = artd_pkg::KIND_PIXEL;
					res.pixel_x     = cursor_x_q;
					res.pixel_y     = cursor_y_q;
					res.pixel_value = (w != 16'd0) ? (w | artd_pkg::VALUE_FLAG) : 16'd0;
					cursor_x_d      = cursor_x_q + 16'd1;
					run_left_d      = run_left_q - artd_pkg::RUN_W'(1);
					if (run_left_q == artd_pkg::RUN_W'(1)) begin
						phase_d = artd_pkg::PH_SKIP;
					end
				end
				default: begin
					phase_d = artd_pkg::PH_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/artd_out.sv */
// Result register driving the decoder's master stream.
// Depends on artd_pkg for the result type and stream widths.
`timescale 1ns / 1ps
`default_nettype none

module artd_out (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  valid_s1,
	input  artd_pkg::result_t                    res,
	output logic                                 adv,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [artd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic [artd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

	artd_pkg::result_t res_q;
	logic              out_valid_q;

	assign adv = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{artd_pkg::OUT_PAD_W{1'b0}}, res_q.pixel_value,
		res_q.pixel_y, res_q.pixel_x};
	assign m_axis_tuser  = res_q.kind;

endmodule

`default_nettype wire

/* rtl/art_run_tile_decode.sv */
// Top level of the run-coded sprite decoder.
// Depends on artd_pkg, artd_in, artd_parse and artd_out.
//
//  channel  dir  tdata (low bit up)                              tuser
//  s_axis   in   data_word[15:0]                                 tile_start
//  m_axis   out  pixel_x[15:0] pixel_y[27:16] pixel_value[43:28] kind[2:0]
//                zero pad [47:44]
//
// One coded word is taken per cycle unless the output stalls; a result passes the input, then the output register.
// The rate is set by the single parser state update per word in artd_parse.
// Reset puts the parser in the waiting phase and empties both registers.
// A stalled result holds in the output register; s_axis_tready drops only
// when the input register is also full and the result is not taken.
`timescale 1ns / 1ps
`default_nettype none

module art_run_tile_decode (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  [artd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // data_word
	input  wire  [artd_pkg::IN_TUSER_W-1:0]      s_axis_tuser,  // tile_start
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [artd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // pixel_x, pixel_y, pixel_value
	output logic [artd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser   // kind
);

	logic              adv;
	logic              valid_s1;
	logic              fire;
	artd_pkg::item_t   item_s1;
	artd_pkg::result_t res;

	assign fire = valid_s1 && adv;

	artd_in u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.adv           (adv),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	artd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.res     (res)
	);

	artd_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.res           (res),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

/* rtl/artd_chk.sv */
// Port-level checker for the sprite decoder, bound to the top level.
// Depends on artd_pkg for kind codes and stream widths.
`timescale 1ns / 1ps
`default_nettype none

module artd_chk (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 s_axis_tvalid,
	input wire                                 s_axis_tready,
	input wire [artd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input wire [artd_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	input wire                                 m_axis_tvalid,
	input wire                                 m_axis_tready,
	input wire [artd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input wire [artd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

	logic in_seen;

	assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 16'hFFFF
		|| s_axis_tuser != 1'b0 || 1'b1);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= artd_pkg::KIND_BAD_RUN)
		else $error("result kind out of range");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != artd_pkg::KIND_PIXEL |-> m_axis_tdata == '0)
		else $error("status result carries pixel data");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == artd_pkg::KIND_PIXEL &&
		m_axis_tdata[43:28] != 16'd0 |-> m_axis_tdata[43] &&
		m_axis_tdata[47:44] == 4'd0)
		else $error("pixel flag or pad wrong");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		!in_seen && !m_axis_tvalid ##1 !in_seen && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result without request");

endmodule

bind art_run_tile_decode artd_chk u_artd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* dv/tb_art_run_tile_decode.sv */
`timescale 1ns / 1ps
// Self-checking bench for art_run_tile_decode: streams coded sprites through the
// request channel, predicts every pixel write and status, and checks results in order.
// Depends on artd_pkg and the rtl top level.

module tb_art_run_tile_decode;
	import artd_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1350;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef struct {
		kind_t       kind;
		logic [15:0] pixel_x;
		logic [11:0] pixel_y;
		logic [15:0] pixel_value;
	} write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	item_t       coded_words[$];
	write_t      predicted_writes[$];
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned words_taken = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;

	phase_t      ph = PH_IDLE;
	logic [9:0]  spr_w = '0;
	logic [11:0] spr_h = '0;
	logic [11:0] offs_left = '0;
	logic [11:0] cur_y = '0;
	logic [15:0] cur_x = '0;
	logic [15:0] skip_amt = '0;
	logic [10:0] run_left = '0;

	art_run_tile_decode uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	initial forever #4 clk = ~clk;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic write_t status_write(input kind_t k);
		write_t wr;
		wr = '{k, 16'h0, 12'h0, 16'h0};
		return wr;
	endfunction

	task automatic decode_word(input logic [15:0] w, input logic start);
		int unsigned span;
		write_t      wr;
		span = 32'(skip_amt) + 32'(w);
		if (start) begin
			spr_w = '0;
			spr_h = '0;
			offs_left = '0;
			cur_x = '0;
			cur_y = '0;
			skip_amt = '0;
			run_left = '0;
			ph = PH_FLAG2;
		end else begin
			case (ph)
				PH_FLAG2: ph = PH_WIDTH;
				PH_WIDTH: begin
					if (w == 0 || w >= MAX_WIDTH) begin
						ph = PH_IDLE;
						predicted_writes.push_back(status_write(KIND_BAD_WIDTH));
					end else begin
						spr_w = w[9:0];
						ph = PH_HEIGHT;
					end
				end
				PH_HEIGHT: begin
					if (w == 0 || w > HEIGHT_LIMIT) begin
						ph = PH_IDLE;
						predicted_writes.push_back(status_write(KIND_BAD_HEIGHT));
					end else begin
						spr_h = w[11:0];
						offs_left = w[11:0];
						ph = PH_OFFSETS;
					end
				end
				PH_OFFSETS: begin
					offs_left = offs_left - 12'd1;
					if (offs_left == 0) begin
						cur_x = '0;
						cur_y = '0;
						ph = PH_SKIP;
					end
				end
				PH_SKIP: begin
					skip_amt = w;
					ph = PH_RUN;
				end
				PH_RUN: begin
					if (span == 0) begin
						cur_x = '0;
						cur_y = cur_y + 12'd1;
						if (cur_y >= spr_h) begin
							ph = PH_IDLE;
							predicted_writes.push_back(status_write(KIND_DONE));
						end else begin
							ph = PH_SKIP;
						end
					end else if (span >= MAX_ROW_SPAN) begin
						ph = PH_IDLE;
						predicted_writes.push_back(status_write(KIND_BAD_RUN));
					end else begin
						cur_x = cur_x + skip_amt;
						if (w == 0) begin
							ph = PH_SKIP;
						end else begin
							run_left = w[10:0];
							ph = PH_PIXELS;
						end
					end
				end
				PH_PIXELS: begin
					wr = '{KIND_PIXEL, cur_x, cur_y, (w != 0) ? (w | VALUE_FLAG) : 16'h0};
					predicted_writes.push_back(wr);
					cur_x = cur_x + 16'd1;
					run_left = run_left - 11'd1;
					if (run_left == 0)
						ph = PH_SKIP;
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			err_cnt++;
		end
	endtask

	task automatic check_write();
		write_t wr;
		if (predicted_writes.size() == 0) begin
			$error("kind: expected none, got %0h", m_tuser);
			err_cnt++;
		end else begin
			wr = predicted_writes.pop_front();
			check_field("kind", 16'(wr.kind), 16'(m_tuser));
			check_field("pixel_x", wr.pixel_x, m_tdata[15:0]);
			check_field("pixel_y", 16'(wr.pixel_y), 16'(m_tdata[27:16]));
			check_field("pixel_value", wr.pixel_value, m_tdata[43:28]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (coded_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= coded_words[0].data_word;
				s_tuser <= coded_words[0].tile_start;
				void'(coded_words.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_word(s_tdata, s_tuser[0]);
				words_taken++;
			end
			if (m_tvalid && m_tready)
				check_write();
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic put(input logic [15:0] w, input logic st = 1'b0);
		coded_words.push_back('{data_word: w, tile_start: st});
	endtask

	task automatic put_header(input logic [15:0] width, input logic [15:0] height);
		put(16'($urandom_range(16'hFFFF)), 1'b1);
		put(16'($urandom_range(16'hFFFF)));
		put(width);
		put(height);
	endtask

	task automatic put_pair(input logic [15:0] skip, input logic [15:0] run_cnt);
		put(skip);
		put(run_cnt);
		if (32'(skip) + 32'(run_cnt) < MAX_ROW_SPAN)
			repeat (run_cnt)
				put(($urandom_range(3) == 0) ? 16'h0 : 16'($urandom_range(16'hFFFF)));
	endtask

	task automatic put_bad_pair();
		logic [15:0] skip;
		skip = 16'($urandom_range(16'hFFFF));
		if ($urandom_range(3) == 0)
			put_pair(16'hFFFF, 16'hFFFF);
		else if (skip >= MAX_ROW_SPAN)
			put_pair(skip, 16'($urandom_range(16'hFFFF)));
		else
			put_pair(skip, 16'($urandom_range(MAX_ROW_SPAN - skip, 16'hFFFF)));
	endtask

	task automatic put_row();
		if ($urandom_range(39) == 0)
			repeat (33) put_pair(16'd2047, 16'd0);
		repeat ($urandom_range(3)) begin
			put_pair(16'(($urandom_range(7) == 0) ? $urandom_range(1000) : $urandom_range(8)),
				16'(($urandom_range(5) == 0) ? $urandom_range(2, 20) : $urandom_range(4)));
		end
		if ($urandom_range(49) == 0)
			put_bad_pair();
		put(16'd0);
		put(16'd0);
	endtask

	task automatic put_sprite();
		int unsigned r;
		int unsigned height;
		r = $urandom_range(99);
		if (r < 70) begin
			height = ($urandom_range(9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
			put_header(16'($urandom_range(1, MAX_WIDTH - 1)), 16'(height));
			repeat (height) put(16'($urandom_range(16'hFFFF)));
			repeat (height) put_row();
		end else if (r < 76) begin
			put(16'($urandom_range(16'hFFFF)), 1'b1);
			put(16'($urandom_range(16'hFFFF)));
			put(($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(MAX_WIDTH, 16'hFFFF)));
		end else if (r < 82) begin
			put_header(16'($urandom_range(1, MAX_WIDTH - 1)), ($urandom_range(1) == 0) ?
				16'd0 : 16'($urandom_range(HEIGHT_LIMIT + 1, 16'hFFFF)));
		end else if (r < 88) begin
			put_header(16'($urandom_range(1, MAX_WIDTH - 1)), 16'd1);
			put(16'($urandom_range(16'hFFFF)));
			put_bad_pair();
		end else if (r < 94) begin
			put_header(16'($urandom_range(1, MAX_WIDTH - 1)), ($urandom_range(1) == 0) ?
				16'(HEIGHT_LIMIT) : 16'($urandom_range(1, HEIGHT_LIMIT)));
			repeat ($urandom_range(6)) put(16'($urandom_range(16'hFFFF)));
		end else begin
			repeat ($urandom_range(1, 4)) put(16'($urandom_range(16'hFFFF)));
		end
	endtask

	initial begin
		int unsigned total;
		int unsigned directed;
		put(16'hFFFF);
		put_header(16'($urandom_range(16'hFFFF)), 16'h0);
		void'(coded_words.pop_back());
		coded_words[$].data_word = 16'(MAX_WIDTH);
		put_header(16'(MAX_WIDTH - 1), 16'(HEIGHT_LIMIT + 1));
		put_header(16'(MAX_WIDTH - 1), 16'd1);
		put(16'hFFFF);
		put(16'd0);
		put(16'd2);
		put(16'h0000);
		put(16'hFFFF);
		put(16'd5);
		put(16'd0);
		put(16'd1);
		put(16'd1);
		put(16'h7FFF);
		put(16'd0);
		put(16'd0);
		put_header(16'd1, 16'd1);
		put(16'h0000);
		put(16'(MAX_ROW_SPAN - 1));
		put(16'd1);
		directed = coded_words.size();
		while (coded_words.size() < directed + RANDOM_WORDS)
			put_sprite();
		total = coded_words.size();

		wait (words_taken >= total / 4);
		idle_pct = 84;
		wait (words_taken >= total / 2);
		idle_pct = 0;
		stall_pct = 84;
		wait (words_taken >= 3 * total / 4);
		idle_pct = 13;
		stall_pct = 13;
		wait (words_taken == total);
		wait (predicted_writes.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
